// File: hdl/fhp_pkg.sv
// Package for the handle pool allocator: transaction structs, operation and status codes.
// Used by the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fhp_pkg;

    localparam int HANDLE_W     = 8;
    localparam int HANDLE_COUNT = 1 << HANDLE_W;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_TRY   = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NONE_FREED = 2'd1,
        ST_NOT_IN_USE = 2'd2,
        ST_EXHAUSTED  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                 operation;
        logic [HANDLE_W-1:0] handle;
    } request_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] granted_handle;
        status_t             status;
    } response_t;

endpackage

`default_nettype wire

// File: hdl/fhp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the free handle queue and the in-use bitmap; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module fhp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/fifo_reuse_handle_pool.sv
// Handle pool allocator, top level. Depends on fhp_pkg and fhp_ram.
// An accepted request waits in item_reg; its response goes to res_reg when it fires.
// Throughput: one transaction per cycle unless stalled; the free queue and in-use bitmap
// RAMs are read every cycle, each with a bypass for a write to the entry being read.
// Reset clears the queue pointers, counters and valid flags at once, then a clearing pass
// over the MAP_DEPTH entries (256 at most) zeroes the in-use bitmap while request_stall is held.
`timescale 1ns / 1ps
`default_nettype none

module fifo_reuse_handle_pool #(
    parameter int POOL_SIZE = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                request_valid,
    output logic                     request_stall,
    input  wire fhp_pkg::request_t   request,
    output logic                     response_valid,
    input  wire logic                response_stall,
    output fhp_pkg::response_t       response
);

    import fhp_pkg::*;

    localparam int MAP_DEPTH = (POOL_SIZE < HANDLE_COUNT) ? POOL_SIZE : HANDLE_COUNT;
    localparam int IDX_W     = $clog2(MAP_DEPTH);
    localparam int CNT_W     = $clog2(MAP_DEPTH + 1);
    localparam int FRESH_W   = $clog2(POOL_SIZE + 1);

    localparam logic [FRESH_W-1:0]  FRESH_END = FRESH_W'(POOL_SIZE);
    localparam logic [FRESH_W-1:0]  FRESH_MAP = FRESH_W'(MAP_DEPTH);
    localparam logic [HANDLE_W:0]   MAP_LIMIT = (HANDLE_W + 1)'(MAP_DEPTH);
    localparam logic [IDX_W-1:0]    RING_LAST = IDX_W'(MAP_DEPTH - 1);

    logic                  item_valid_reg;
    logic                  item_valid_next;
    request_t              item_reg;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    response_t             res_reg;
    response_t             res_item;
    logic                  fire;
    logic                  accept_in;
    logic                  accept_out;

    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      head_next;
    logic [IDX_W-1:0]      tail_reg;
    logic [IDX_W-1:0]      tail_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [FRESH_W-1:0]    fresh_reg;
    logic [FRESH_W-1:0]    fresh_next;

    logic                  wr_en;
    logic [HANDLE_W-1:0]   ram_rd_data;
    logic [HANDLE_W-1:0]   head_data;
    logic                  bypass_hit_reg;
    logic [HANDLE_W-1:0]   bypass_data_reg;

    logic                  clear_busy_reg;
    logic [IDX_W-1:0]      clear_idx_reg;
    logic                  use_we;
    logic [IDX_W-1:0]      use_addr;
    logic                  use_data;
    logic                  map_wr_en;
    logic [IDX_W-1:0]      map_wr_addr;
    logic                  map_wr_data;
    logic [IDX_W-1:0]      map_rd_addr;
    logic                  map_rd_data;
    logic                  map_byp_hit_reg;
    logic                  map_byp_data_reg;
    logic                  in_use_bit;

    function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] pos);
        ring_adv = (pos == RING_LAST) ? '0 : pos + 1'b1;
    endfunction

    assign fire          = item_valid_reg && (!res_valid_reg || !response_stall);
    assign request_stall = clear_busy_reg || (item_valid_reg && !fire);
    assign accept_in     = request_valid && !request_stall;
    assign accept_out    = res_valid_reg && !response_stall;

    assign response_valid = res_valid_reg;
    assign response       = res_reg;

    assign head_data = bypass_hit_reg ? bypass_data_reg : ram_rd_data;

    assign map_wr_en   = clear_busy_reg || use_we;
    assign map_wr_addr = clear_busy_reg ? clear_idx_reg : use_addr;
    assign map_wr_data = !clear_busy_reg && use_data;
    assign map_rd_addr = accept_in ? IDX_W'(request.handle) : IDX_W'(item_reg.handle);
    assign in_use_bit  = map_byp_hit_reg ? map_byp_data_reg : map_rd_data;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept_in)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (accept_out)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        fresh_next  = fresh_reg;
        wr_en       = 1'b0;
        use_we      = 1'b0;
        use_addr    = '0;
        use_data    = 1'b0;
        res_item.granted_handle = '0;
        res_item.status         = ST_OK;

        if (fire)
        begin
            case (item_reg.operation)
                OP_ALLOC:
                begin
                    if (count_reg != '0)
                    begin
                        res_item.granted_handle = head_data;
                        use_we     = 1'b1;
                        use_addr   = IDX_W'(head_data);
                        use_data   = 1'b1;
                        head_next  = ring_adv(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                    else if (fresh_reg != FRESH_END)
                    begin
                        res_item.granted_handle = HANDLE_W'(fresh_reg);
                        if (fresh_reg < FRESH_MAP)
                        begin
                            use_we   = 1'b1;
                            use_addr = IDX_W'(fresh_reg);
                            use_data = 1'b1;
                        end
                        fresh_next = fresh_reg + 1'b1;
                    end
                    else
                    begin
                        res_item.status = ST_EXHAUSTED;
                    end
                end
                OP_TRY:
                begin
                    if (count_reg != '0)
                    begin
                        res_item.granted_handle = head_data;
                        use_we     = 1'b1;
                        use_addr   = IDX_W'(head_data);
                        use_data   = 1'b1;
                        head_next  = ring_adv(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        res_item.status = ST_NONE_FREED;
                    end
                end
                OP_FREE:
                begin
                    if (({1'b0, item_reg.handle} >= MAP_LIMIT) || !in_use_bit)
                    begin
                        res_item.status = ST_NOT_IN_USE;
                    end
                    else
                    begin
                        use_we     = 1'b1;
                        use_addr   = IDX_W'(item_reg.handle);
                        use_data   = 1'b0;
                        wr_en      = 1'b1;
                        tail_next  = ring_adv(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    res_item.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            fresh_reg       <= '0;
            bypass_hit_reg  <= 1'b0;
            clear_busy_reg  <= 1'b1;
            clear_idx_reg   <= '0;
            map_byp_hit_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg  <= item_valid_next;
            res_valid_reg   <= res_valid_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            fresh_reg       <= fresh_next;
            bypass_hit_reg  <= wr_en && (tail_reg == head_next);
            map_byp_hit_reg <= map_wr_en && (map_wr_addr == map_rd_addr);
            if (clear_busy_reg)
            begin
                clear_idx_reg <= ring_adv(clear_idx_reg);
                if (clear_idx_reg == RING_LAST)
                begin
                    clear_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            item_reg <= request;
        end
        if (fire)
        begin
            res_reg <= res_item;
        end
        bypass_data_reg  <= item_reg.handle;
        map_byp_data_reg <= map_wr_data;
    end

    fhp_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (MAP_DEPTH)
    ) u_free_queue (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (item_reg.handle),
        .rd_addr (head_next),
        .rd_data (ram_rd_data)
    );

    fhp_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_in_use_map (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the handle pool allocator fifo_reuse_handle_pool.
// Clocked driver and monitor with randomised gaps; a predictor of the pool checks
// every response in order. Depends on fhp_pkg and the RTL in hdl/.
`timescale 1ns / 1ps

module testbench;
    import fhp_pkg::*;

    localparam int POOL        = 256;
    localparam int LIMIT       = 200000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        request_t req;
        bit       sync;
    } req_item_t;

    logic      clk            = 1'b0;
    logic      rst_n          = 1'b0;
    logic      request_valid  = 1'b0;
    logic      request_stall;
    request_t  request        = '0;
    logic      response_valid;
    logic      response_stall = 1'b0;
    response_t response;

    req_item_t request_q[$];
    response_t predicted_rsp_q[$];

    bit         pool_used[POOL];
    logic [7:0] freed_handles[$];
    int         fresh_issued = 0;

    int gen_issued  = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_offered   = 0;
    int n_seen      = 0;
    int n_fail      = 0;
    int drv_gap     = 0;
    int mon_gap     = 0;
    int hold_left   = 0;
    bit hold_armed  = 1'b1;
    int cycle_count = 0;

    fifo_reuse_handle_pool #(
        .POOL_SIZE(POOL)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .response_valid(response_valid),
        .response_stall(response_stall),
        .response      (response)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic response_t pool_predict(request_t r);
        response_t  rsp;
        logic [7:0] h;
        rsp.granted_handle = '0;
        rsp.status         = ST_OK;
        case (r.operation)
            OP_ALLOC:
            begin
                if (freed_handles.size() != 0)
                begin
                    h = freed_handles[0];
                    freed_handles.delete(0);
                    pool_used[h] = 1'b1;
                    rsp.granted_handle = h;
                end
                else if (fresh_issued < POOL)
                begin
                    h = fresh_issued[7:0];
                    pool_used[h] = 1'b1;
                    rsp.granted_handle = h;
                    fresh_issued++;
                end
                else
                    rsp.status = ST_EXHAUSTED;
            end
            OP_TRY:
            begin
                if (freed_handles.size() != 0)
                begin
                    h = freed_handles[0];
                    freed_handles.delete(0);
                    pool_used[h] = 1'b1;
                    rsp.granted_handle = h;
                end
                else
                    rsp.status = ST_NONE_FREED;
            end
            OP_FREE:
            begin
                if (int'(r.handle) >= POOL || !pool_used[r.handle])
                    rsp.status = ST_NOT_IN_USE;
                else
                begin
                    pool_used[r.handle] = 1'b0;
                    freed_handles.insert(freed_handles.size(), r.handle);
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic queue_op(logic [1:0] op, logic [7:0] h, bit sync);
        req_item_t it;
        it.req.operation = op_t'(op);
        it.req.handle    = h;
        it.sync          = sync;
        if (op == OP_ALLOC && gen_issued < POOL)
            gen_issued++;
        request_q.insert(request_q.size(), it);
    endtask

    // Frees mostly target handles already issued, so that they tend to be in use
    task automatic queue_mixed(int n, int alloc_pct, int try_pct, int free_pct, bit sync_first);
        int         roll;
        logic [7:0] h;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            h    = 8'($urandom_range(0, 255));
            if (roll < alloc_pct)
                queue_op(OP_ALLOC, h, sync_first && i == 0);
            else if (roll < alloc_pct + try_pct)
                queue_op(OP_TRY, h, sync_first && i == 0);
            else if (roll < alloc_pct + try_pct + free_pct)
            begin
                if (gen_issued > 0)
                    h = 8'($urandom_range(0, gen_issued - 1));
                queue_op(OP_FREE, h, sync_first && i == 0);
            end
            else if (roll[0])
                queue_op(OP_FREE, h, sync_first && i == 0);
            else
                queue_op(OP_UNUSED, h, sync_first && i == 0);
        end
    endtask

    initial
    begin
        int perm[POOL];
        int j;
        int t;

        queue_op(OP_TRY,    8'h00, 1'b0);
        queue_op(OP_FREE,   8'h00, 1'b0);
        queue_op(OP_ALLOC,  8'hFF, 1'b0);
        queue_op(OP_ALLOC,  8'h00, 1'b0);
        queue_op(OP_ALLOC,  8'h81, 1'b0);
        queue_op(OP_FREE,   8'hFF, 1'b0);
        queue_op(OP_FREE,   8'h01, 1'b0);
        queue_op(OP_FREE,   8'h01, 1'b0);
        queue_op(OP_UNUSED, 8'hAA, 1'b0);
        queue_op(OP_FREE,   8'h00, 1'b0);
        queue_op(OP_TRY,    8'h7F, 1'b0);
        queue_op(OP_ALLOC,  8'h3C, 1'b0);
        queue_op(OP_TRY,    8'hC3, 1'b0);
        queue_op(OP_ALLOC,  8'h00, 1'b0);
        queue_op(OP_UNUSED, 8'h55, 1'b0);
        queue_op(OP_FREE,   8'h02, 1'b0);
        queue_op(OP_FREE,   8'h03, 1'b0);
        queue_op(OP_ALLOC,  8'hF0, 1'b0);
        queue_op(OP_ALLOC,  8'h0F, 1'b0);

        queue_mixed(290, 92, 3, 3, 1'b1);
        queue_mixed(245, 30, 15, 40, 1'b1);

        for (int i = 0; i < POOL; i++)
            perm[i] = i;
        for (int i = POOL - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < POOL; i++)
            queue_op(OP_FREE, perm[i][7:0], i == 0);

        queue_mixed(40, 35, 25, 30, 1'b1);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(negedge clk);
        while (request_q.size() != 0 || request_valid || n_accepted != n_checked)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (predicted_rsp_q.size() != 0)
        begin
            $error("%0d responses never arrived", predicted_rsp_q.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Driver: hold the transaction while stalled, pause at a sync point until drained
    always @(posedge clk or negedge rst_n)
    begin
        req_item_t nxt_item;
        if (!rst_n)
        begin
            request_valid <= 1'b0;
            request       <= '0;
            drv_gap = 0;
        end
        else
        begin
            if (request_valid && !request_stall)
            begin
                predicted_rsp_q.insert(predicted_rsp_q.size(), pool_predict(request));
                n_accepted <= n_accepted + 1;
            end
            if (!request_valid || !request_stall)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap = drv_gap - 1;
                    request_valid <= 1'b0;
                end
                else if (request_q.size() != 0 &&
                         (!request_q[0].sync || (!request_valid && n_accepted == n_checked)))
                begin
                    nxt_item = request_q[0];
                    request_q.delete(0);
                    request       <= nxt_item.req;
                    request_valid <= 1'b1;
                    drv_gap = ((n_offered / 32) % 4 == 0) ? 0 : $urandom_range(0, 5);
                    n_offered++;
                end
                else
                    request_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each response transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            response_stall <= 1'b0;
            mon_gap = 0;
        end
        else
        begin
            if (response_valid && !response_stall)
            begin
                if (predicted_rsp_q.size() == 0)
                begin
                    $error("unexpected response: granted_handle %0d status %0d",
                           response.granted_handle, response.status);
                    n_fail++;
                end
                else
                begin
                    want = predicted_rsp_q[0];
                    predicted_rsp_q.delete(0);
                    if (response.granted_handle !== want.granted_handle)
                    begin
                        $error("granted_handle: expected %0d, actual %0d",
                               want.granted_handle, response.granted_handle);
                        n_fail++;
                    end
                    if (response.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, response.status);
                        n_fail++;
                    end
                    n_checked <= n_checked + 1;
                end
                mon_gap = ((n_seen / 40) % 3 == 0) ? 0 : $urandom_range(0, 5);
                n_seen++;
            end
            if (hold_left > 0)
                response_stall <= 1'b1;
            else if (mon_gap > 0)
            begin
                mon_gap = mon_gap - 1;
                response_stall <= 1'b1;
            end
            else
                response_stall <= 1'b0;
        end
    end

    // Hold off the response side once, long enough to back up the request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && n_accepted >= HOLD_AT)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
